FILE: hw/rtl/ppt_pkg.sv
package ppt_pkg;

  localparam logic [2:0] OP_CREATE    = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_LOOKUP_ID = 3'd2;
  localparam logic [2:0] OP_LOOKUP_NM = 3'd3;
  localparam logic [2:0] OP_READ_POS  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_PRIO  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_KERNEL    = 3'd4;

  localparam int POS_RANGE = 16;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [63:0]        name_key;
    logic signed [7:0]  priority_in;
    logic [15:0]        id_key;
    logic [3:0]         position;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] proc_id;
    logic [15:0] parent_id;
    logic [6:0]  priority_out;
    logic        run_state;
    logic [63:0] name_out;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] parent;
    logic [6:0]  prio;
    logic        run;
    logic [63:0] name;
  } entry_t;

  typedef struct packed {
    logic cmp;
    logic load;
    logic up;
    logic down;
  } cell_ctl_t;

  typedef struct packed {
    logic [15:0] id;
    logic [63:0] name;
    logic [6:0]  prio;
  } cell_key_t;

  typedef struct packed {
    logic id;
    logic name;
    logic prio_ge;
  } cell_hit_t;

endpackage

FILE: hw/rtl/process_priority_table.sv
// Priority-sorted process table built as a row of cells, one entry per cell,
// with the kernel entry fixed in cell zero.
// Input channel: in_valid / in_stall carry one request (in_t) per transfer:
// create, remove by id, lookup by id, lookup by name or read by position.
// Output channel: out_valid / out_stall carry exactly one result (out_t) per
// request. Failed requests report only a status, all other fields zero.
// Timing: a request is taken in the idle state, every cell compares its entry
// to the request in the compare state, and in the resolve state the first
// matches are resolved, the cells shift for an insert or delete and the
// result is registered. The result is valid from the following cycle, and
// a new request can be taken in that same cycle. Only one request is in
// the table at a time, as in_stall is high outside the idle state.
// While the receiver stalls, the result holds and the block takes one more
// request, then waits in the resolve step until the result is transferred.
// cfg_we / cfg_wdata write the kernel name key; write it only while idle.
// Reset (rst, synchronous): table holds only the kernel entry, the next id
// is FIRST_ID + 1, the kernel name key is 0 and no result is pending.
module process_priority_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int FIRST_ID    = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ppt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ppt_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [63:0]   cfg_wdata
);
  import ppt_pkg::*;

  localparam int N = TABLE_DEPTH;
  localparam int POS_CELLS = (N < POS_RANGE) ? N : POS_RANGE;
  localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {S_IDLE, S_COMPARE, S_RESOLVE} state_t;

  state_t      state;
  in_t         req;
  logic [15:0] next_id;
  logic [63:0] kernel_name_key;
  logic        kernel_hit;

  entry_t      ent   [N];
  logic        vld   [N];
  cell_hit_t   hits  [N];
  cell_ctl_t   ctl   [N];

  entry_t      init_kernel;
  entry_t      new_entry;
  cell_key_t   key;

  logic [N-1:0] valid_vec, id_vec, name_vec, ge_vec, pos_vec;
  logic [N-1:0] id_first, name_first, ge_first, free_first, ins_vec;
  logic [N-1:0] up_mask, down_mask, rd_sel;
  logic [N-1:0] load_vec, up_vec, down_vec;
  entry_t       rd_entry;
  out_t         res;
  logic         bump_id, apply;

  assign init_kernel = '{id: 16'(FIRST_ID), parent: 16'(FIRST_ID), prio: 7'd0,
                         run: 1'b1, name: 64'd0};

  assign key = '{id: req.id_key, name: req.name_key, prio: req.priority_in[6:0]};

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_vec[i] = vld[i];
      id_vec[i]    = hits[i].id;
      name_vec[i]  = (i == 0) ? kernel_hit : hits[i].name;
      ge_vec[i]    = (i == 0) ? 1'b0 : hits[i].prio_ge;
      pos_vec[i]   = 1'b0;
    end
    for (int i = 0; i < POS_CELLS; i++) begin
      pos_vec[i] = vld[i] && (req.position == 4'(i));
    end
  end

  // Isolate the lowest set bit: first match in queue order
  assign id_first   = id_vec & (~id_vec + ONE);
  assign name_first = name_vec & (~name_vec + ONE);
  assign ge_first   = ge_vec & (~ge_vec + ONE);
  assign free_first = ~valid_vec & (valid_vec + ONE);
  assign ins_vec    = (|ge_vec) ? ge_first : free_first;
  assign up_mask    = ~(ins_vec | (ins_vec - ONE));
  assign down_mask  = ~(id_first - ONE);

  assign new_entry = '{id: next_id, parent: (|id_vec) ? req.id_key : 16'd0,
                       prio: req.priority_in[6:0], run: 1'b0, name: req.name_key};

  always_comb begin
    case (req.opcode)
      OP_REMOVE, OP_LOOKUP_ID: rd_sel = id_first;
      OP_LOOKUP_NM:            rd_sel = name_first;
      OP_READ_POS:             rd_sel = pos_vec;
      default:                 rd_sel = '0;
    endcase
  end

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < N; i++) begin
      if (rd_sel[i]) begin
        rd_entry = rd_entry | ent[i];
      end
    end
    if (rd_sel[0]) begin
      rd_entry.name = kernel_name_key;
    end
  end

  always_comb begin
    res      = '0;
    load_vec = '0;
    up_vec   = '0;
    down_vec = '0;
    bump_id  = 1'b0;
    case (req.opcode)
      OP_CREATE: begin
        if (req.priority_in[7] || (req.priority_in == 8'sd0)) begin
          res.status = ST_BAD_PRIO;
        end else if (valid_vec[N-1]) begin
          res.status = ST_FULL;
        end else begin
          res.status       = ST_OK;
          res.proc_id      = new_entry.id;
          res.parent_id    = new_entry.parent;
          res.priority_out = new_entry.prio;
          res.run_state    = new_entry.run;
          res.name_out     = new_entry.name;
          load_vec         = ins_vec;
          up_vec           = up_mask;
          bump_id          = 1'b1;
        end
      end
      OP_REMOVE, OP_LOOKUP_ID, OP_LOOKUP_NM, OP_READ_POS: begin
        if (!(|rd_sel)) begin
          res.status = ST_NOT_FOUND;
        end else if ((req.opcode == OP_REMOVE) && rd_sel[0]) begin
          res.status = ST_KERNEL;
        end else begin
          res.status       = ST_OK;
          res.proc_id      = rd_entry.id;
          res.parent_id    = rd_entry.parent;
          res.priority_out = rd_entry.prio;
          res.run_state    = rd_entry.run;
          res.name_out     = rd_entry.name;
          if (req.opcode == OP_REMOVE) begin
            down_vec = down_mask;
          end
        end
      end
      default: res.status = ST_NOT_FOUND;
    endcase
  end

  // Hold the resolve step while the previous result is still stalled
  assign apply    = (state == S_RESOLVE) && !(out_valid && out_stall);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctl[i].cmp  = (state == S_COMPARE);
      ctl[i].load = apply && load_vec[i];
      ctl[i].up   = apply && up_vec[i];
      ctl[i].down = apply && down_vec[i];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, right_v;
    if (g == 0) begin : g_head
      assign left_e = init_kernel;
      assign left_v = 1'b1;
    end else begin : g_mid
      assign left_e = ent[g-1];
      assign left_v = vld[g-1];
    end
    if (g == N-1) begin : g_tail
      assign right_e = new_entry;
      assign right_v = 1'b0;
    end else begin : g_body
      assign right_e = ent[g+1];
      assign right_v = vld[g+1];
    end
    ppt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .init_entry  (init_kernel),
      .init_valid  (g == 0),
      .ctl         (ctl[g]),
      .key         (key),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .right_entry (right_e),
      .right_valid (right_v),
      .entry       (ent[g]),
      .valid       (vld[g]),
      .hit         (hits[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      out_data        <= '0;
      req             <= '0;
      next_id         <= 16'(FIRST_ID + 1);
      kernel_name_key <= '0;
      kernel_hit      <= 1'b0;
    end else begin
      if (cfg_we) begin
        kernel_name_key <= cfg_wdata;
      end
      if (out_valid && !out_stall && !apply) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_COMPARE;
          end
        end
        S_COMPARE: begin
          kernel_hit <= (kernel_name_key == req.name_key);
          state      <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (apply) begin
            out_valid <= 1'b1;
            out_data  <= res;
            if (bump_id) begin
              next_id <= next_id + 16'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ppt_cell.sv
module ppt_cell (
  input  logic               clk,
  input  logic               rst,
  input  ppt_pkg::entry_t    init_entry,
  input  logic               init_valid,
  input  ppt_pkg::cell_ctl_t ctl,
  input  ppt_pkg::cell_key_t key,
  input  ppt_pkg::entry_t    new_entry,
  input  ppt_pkg::entry_t    left_entry,
  input  logic               left_valid,
  input  ppt_pkg::entry_t    right_entry,
  input  logic               right_valid,
  output ppt_pkg::entry_t    entry,
  output logic               valid,
  output ppt_pkg::cell_hit_t hit
);
  import ppt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= init_entry;
      valid <= init_valid;
      hit   <= '0;
    end else begin
      if (ctl.load) begin
        entry <= new_entry;
        valid <= 1'b1;
      end else if (ctl.up) begin
        entry <= left_entry;
        valid <= left_valid;
      end else if (ctl.down) begin
        entry <= right_entry;
        valid <= right_valid;
      end
      if (ctl.cmp) begin
        hit.id      <= valid && (entry.id == key.id);
        hit.name    <= valid && (entry.name == key.name);
        hit.prio_ge <= valid && (entry.prio >= key.prio);
      end
    end
  end

endmodule

FILE: hw/rtl/ppt_checker.sv
module ppt_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ppt_pkg::out_t out_data
);
  import ppt_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One request at a time: the block stalls right after a transfer in
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // A new result appears only out of the resolve step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

  // Failed requests report nothing but a status
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.proc_id == 16'd0) && (out_data.parent_id == 16'd0) &&
      (out_data.priority_out == 7'd0) && !out_data.run_state &&
      (out_data.name_out == 64'd0))
    else $error("failed result carries entry fields");

endmodule

bind process_priority_table ppt_checker u_ppt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: bench/tb_process_priority_table.sv
`timescale 1ns / 1ps

module tb_process_priority_table;
  import ppt_pkg::*;

  localparam int DEPTH    = 16;
  localparam int FIRST_ID = 1024;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  process_priority_table #(
    .TABLE_DEPTH(DEPTH),
    .FIRST_ID   (FIRST_ID)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the process table
  entry_t      procs [DEPTH];
  int          proc_count;
  logic [15:0] id_next;
  logic [63:0] kern_name;

  in_t  pending_reqs [$];
  out_t predicted [$];

  bit pace_on = 1'b1;
  bit burst   = 1'b0;
  int in_gap;
  int stall_left;

  int n_req, n_checked, n_bad, n_created, n_removed, n_full, n_wraps, n_cfg;

  function automatic int find_slot(logic [15:0] id);
    int at;
    int i;
    at = -1;
    for (i = proc_count - 1; i >= 0; i--)
      if (procs[i].id == id) at = i;
    return at;
  endfunction

  function automatic out_t entry_result(int pos);
    out_t r;
    r = '0;
    r.status       = ST_OK;
    r.proc_id      = procs[pos].id;
    r.parent_id    = procs[pos].parent;
    r.priority_out = procs[pos].prio;
    r.run_state    = procs[pos].run;
    r.name_out     = (pos == 0) ? kern_name : procs[pos].name;
    return r;
  endfunction

  // Apply one request to the shadow table and return the result it produces.
  function automatic out_t table_apply(in_t req);
    out_t        r;
    int          at;
    int          i;
    logic [15:0] par;
    r = '0;
    r.status = ST_NOT_FOUND;
    case (req.opcode)
      OP_CREATE: begin
        if (req.priority_in[7] || req.priority_in == 8'd0) begin
          r.status = ST_BAD_PRIO;
        end else if (proc_count >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          par = (find_slot(req.id_key) >= 0) ? req.id_key : 16'd0;
          // insert ahead of the first non-kernel entry of equal or higher value
          at = proc_count;
          for (i = proc_count - 1; i >= 1; i--)
            if (procs[i].prio >= req.priority_in[6:0]) at = i;
          for (i = proc_count; i > at; i--)
            procs[i] = procs[i - 1];
          procs[at].id     = id_next;
          procs[at].parent = par;
          procs[at].prio   = req.priority_in[6:0];
          procs[at].run    = 1'b0;
          procs[at].name   = req.name_key;
          id_next = id_next + 16'd1;
          if (id_next == 16'd0) n_wraps++;
          proc_count++;
          n_created++;
          r = entry_result(at);
        end
      end
      OP_REMOVE: begin
        at = find_slot(req.id_key);
        if (at == 0) begin
          r.status = ST_KERNEL;
        end else if (at > 0) begin
          r = entry_result(at);
          for (i = at; i < proc_count - 1; i++)
            procs[i] = procs[i + 1];
          proc_count--;
          n_removed++;
        end
      end
      OP_LOOKUP_ID: begin
        at = find_slot(req.id_key);
        if (at >= 0) r = entry_result(at);
      end
      OP_LOOKUP_NM: begin
        at = -1;
        for (i = proc_count - 1; i >= 0; i--)
          if (((i == 0) ? kern_name : procs[i].name) == req.name_key) at = i;
        if (at >= 0) r = entry_result(at);
      end
      OP_READ_POS: begin
        if (int'(req.position) < proc_count) r = entry_result(int'(req.position));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    return (pace_on && !burst) ? int'($urandom_range(0, 14)) : 0;
  endfunction

  // Driver: one transfer per request, random gap after each while pacing is on and no burst runs
  always @(posedge clk) begin : driver
    int n;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (in_valid && !in_stall) begin
      predicted.push_back(table_apply(in_data));
      n_req++;
      n = draw_gap();
      if (n == 0 && pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_gap <= n;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: check each result transfer, then stall for a random count while pacing is on and no burst runs
  always @(posedge clk) begin : monitor
    out_t want;
    int   n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n_checked++;
      if (predicted.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("result with nothing pending: %h", out_data);
      end else begin
        want = predicted.pop_front();
        if (out_data !== want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("result %0d expected: st=%0d id=%h parent=%h prio=%0d run=%b name=%h",
                     n_checked, want.status, want.proc_id, want.parent_id,
                     want.priority_out, want.run_state, want.name_out);
            $display("result %0d actual:   st=%0d id=%h parent=%h prio=%0d run=%b name=%h",
                     n_checked, out_data.status, out_data.proc_id, out_data.parent_id,
                     out_data.priority_out, out_data.run_state, out_data.name_out);
          end
        end
      end
      n = draw_gap();
      out_stall <= (n != 0);
      stall_left <= n;
    end else if (out_stall) begin
      if (stall_left <= 1) out_stall <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  function automatic in_t mk_req(logic [2:0] op, logic [63:0] nm, logic [7:0] pr,
                                 logic [15:0] id, logic [3:0] pos);
    in_t r;
    r.opcode      = op;
    r.name_key    = nm;
    r.priority_in = pr;
    r.id_key      = id;
    r.position    = pos;
    return r;
  endfunction

  function automatic logic [63:0] pool_name(int k);
    case (k)
      0:       return 64'h696e_6974_0000_0000;
      1:       return 64'h7368_656c_6c00_0000;
      2:       return 64'h6c6f_6767_6572_6400;
      3:       return 64'h8000_0000_0000_0001;
      4:       return 64'h0000_0000_0000_0001;
      default: return 64'h7fff_ffff_ffff_fffe;
    endcase
  endfunction

  function automatic logic [63:0] pick_name();
    case ($urandom_range(0, 4))
      0:       return {$urandom, $urandom};
      1:       return kern_name;
      2:       return (proc_count > 1) ? procs[$urandom_range(1, proc_count - 1)].name
                                       : pool_name(int'($urandom_range(0, 5)));
      default: return pool_name(int'($urandom_range(0, 5)));
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return id_next + 16'($urandom_range(0, 3));
      2:       return 16'(FIRST_ID);
      default: return procs[$urandom_range(0, proc_count - 1)].id;
    endcase
  endfunction

  function automatic logic [7:0] pick_prio();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return 8'h00;
          1:       return 8'h80;
          2:       return 8'hff;
          default: return 8'h7f;
        endcase
      end
      2, 3, 4: return 8'($urandom_range(1, 6));
      default: return 8'($urandom_range(1, 127));
    endcase
  endfunction

  function automatic in_t random_req(bit filling);
    in_t r;
    int  roll;
    int  cw;
    int  rw;
    r.opcode      = OP_READ_POS;
    r.name_key    = {$urandom, $urandom};
    r.priority_in = 8'($urandom);
    r.id_key      = 16'($urandom);
    r.position    = 4'($urandom);
    cw = filling ? 40 : 15;
    rw = filling ? 12 : 35;
    roll = $urandom_range(0, 99);
    if (roll < cw) begin
      r.opcode      = OP_CREATE;
      r.name_key    = pick_name();
      r.priority_in = pick_prio();
      r.id_key      = pick_id();
    end else if (roll < cw + rw) begin
      r.opcode = OP_REMOVE;
      r.id_key = pick_id();
    end else if (roll < cw + rw + 18) begin
      r.opcode = OP_LOOKUP_ID;
      r.id_key = pick_id();
    end else if (roll < cw + rw + 34) begin
      r.opcode   = OP_LOOKUP_NM;
      r.name_key = pick_name();
    end else if (roll >= 97) begin
      r.opcode = OP_READ_POS + 3'($urandom_range(1, 3));
    end
    return r;
  endfunction

  task automatic send_req(in_t r);
    while (pending_reqs.size() > 1) @(posedge clk);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || predicted.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_kernel_name(logic [63:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    kern_name = v;
    n_cfg++;
  endtask

  task automatic run_random(int count);
    int k;
    bit filling;
    filling = 1'b1;
    for (k = 0; k < count; k++) begin
      if (k % 30 == 0) burst = ($urandom_range(0, 3) == 0);
      // swing between a full table and a nearly empty one
      if (proc_count >= DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (proc_count <= 1) filling = 1'b1;
      send_req(random_req(filling));
    end
    burst = 1'b0;
  endtask

  initial begin : stimulus
    int          i;
    int          n_pairs;
    logic [15:0] base;
    logic [15:0] ids [$];
    for (i = 0; i < DEPTH; i++) procs[i] = '0;
    procs[0].id     = 16'(FIRST_ID);
    procs[0].parent = 16'(FIRST_ID);
    procs[0].run    = 1'b1;
    proc_count = 1;
    id_next    = 16'(FIRST_ID + 1);
    kern_name  = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_kernel_name('1);
    send_req(mk_req(OP_READ_POS, '0, 8'h00, 16'h0000, 4'd0));
    send_req(mk_req(OP_LOOKUP_ID, '0, 8'h00, 16'(FIRST_ID), 4'd0));
    send_req(mk_req(OP_LOOKUP_NM, '1, 8'h00, 16'h0000, 4'd0));
    send_req(mk_req(OP_REMOVE, '0, 8'h00, 16'(FIRST_ID), 4'd0));
    send_req(mk_req(OP_CREATE, pool_name(0), 8'h00, 16'(FIRST_ID), 4'd0));
    send_req(mk_req(OP_CREATE, pool_name(0), 8'h80, 16'(FIRST_ID), 4'd0));
    send_req(mk_req(OP_CREATE, pool_name(0), 8'hff, 16'(FIRST_ID), 4'd0));
    send_req(mk_req(OP_CREATE, '0, 8'h7f, 16'(FIRST_ID), 4'hf));
    // unknown parent, then an equal priority that must land ahead of it
    send_req(mk_req(OP_CREATE, '1, 8'h01, 16'hffff, 4'd0));
    send_req(mk_req(OP_CREATE, pool_name(1), 8'h01, 16'(FIRST_ID + 1), 4'd0));
    send_req(mk_req(OP_CREATE, pool_name(2), 8'h40, 16'(FIRST_ID + 3), 4'd0));
    send_req(mk_req(OP_LOOKUP_NM, '1, 8'h00, 16'h0000, 4'd0));
    send_req(mk_req(OP_LOOKUP_NM, '0, 8'h00, 16'h0000, 4'd0));
    send_req(mk_req(OP_READ_POS, '0, 8'h00, 16'h0000, 4'd15));
    send_req(mk_req(OP_READ_POS, '0, 8'h00, 16'h0000, 4'd4));
    send_req(mk_req(OP_READ_POS, '0, 8'h00, 16'h0000, 4'd5));
    send_req(mk_req(OP_REMOVE, '0, 8'h00, 16'hffff, 4'd0));
    send_req(mk_req(OP_REMOVE, '0, 8'h00, 16'(FIRST_ID + 2), 4'd0));
    send_req(mk_req(OP_LOOKUP_ID, '0, 8'h00, 16'(FIRST_ID + 2), 4'd0));
    send_req(mk_req(OP_LOOKUP_ID, '0, 8'h00, 16'h0000, 4'd0));
    for (i = 1; i <= 3; i++)
      send_req(mk_req(OP_READ_POS + 3'(i), '1, 8'hff, 16'hffff, 4'hf));

    run_random(130);
    set_kernel_name('0);
    run_random(130);
    set_kernel_name({$urandom, $urandom});
    run_random(130);

    // Empty the table, then run create/remove pairs back to back.
    wait_idle();
    for (i = 1; i < proc_count; i++) ids.push_back(procs[i].id);
    while (ids.size() > 0)
      send_req(mk_req(OP_REMOVE, '0, 8'h00, ids.pop_front(), 4'd0));
    wait_idle();
    pace_on = 1'b0;
    base = id_next;
    n_pairs = 20;
    for (i = 0; i < n_pairs; i++) begin
      send_req(mk_req(OP_CREATE, {$urandom, $urandom}, 8'($urandom_range(1, 127)),
                      pick_id(), 4'($urandom)));
      send_req(mk_req(OP_REMOVE, pick_name(), 8'($urandom), 16'(base + 16'(i)),
                      4'($urandom)));
    end
    wait_idle();
    pace_on = 1'b1;

    set_kernel_name(pool_name(1));
    run_random(60);
    wait_idle();

    $display("%0d requests, %0d results checked: %0d created, %0d removed, %0d full rejects",
             n_req, n_checked, n_created, n_removed, n_full);
    $display("id counter wrapped %0d time(s), kernel name key written %0d times",
             n_wraps, n_cfg);
    if (n_bad == 0)
      $display("tb_process_priority_table: PASS");
    else
      $display("tb_process_priority_table: FAIL");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_process_priority_table: FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_cell.sv
hw/rtl/process_priority_table.sv
hw/rtl/ppt_checker.sv
bench/tb_process_priority_table.sv
